/* sv/mur_pkg.sv */
// Shared types, constants and helper functions for the multichannel ultrasonic ranger.
// Stand-alone package: no dependencies.
`default_nettype none

package mur_pkg;

   // Number of sensors polled in turn, and the width of a sensor index.
   localparam int unsigned SENSORS  = 8;
   localparam int unsigned SENSOR_W = 3;

   // Register reset values.
   localparam logic [7:0]  TRIGGER_TICKS_RESET   = 8'd10;
   localparam logic [15:0] ECHO_WAIT_LIMIT_RESET = 16'd1000;
   localparam logic [15:0] ECHO_MAX_TICKS_RESET  = 16'd5800;
   localparam logic [3:0]  REPORTED_COUNT_RESET  = 4'd8;

   // Register indexes on the configuration port (byte address / 4).
   localparam logic [1:0] REG_TRIGGER_TICKS   = 2'd0;
   localparam logic [1:0] REG_ECHO_WAIT_LIMIT = 2'd1;
   localparam logic [1:0] REG_ECHO_MAX_TICKS  = 2'd2;

   // Request kinds.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_HOST = 1'b1;

   // Host commands, carried in the upper nibble of a host byte.
   localparam logic [3:0] CMD_NOP       = 4'd0;
   localparam logic [3:0] CMD_SET_COUNT = 4'd1;
   localparam logic [3:0] CMD_GET_COUNT = 4'd2;
   localparam logic [3:0] CMD_READ      = 4'd3;

   localparam logic [7:0] ERROR_REPLY = 8'hFF;

   // Reading conversion: microseconds of echo divided by 58 gives centimetres.
   localparam int unsigned US_PER_CM   = 58;
   localparam int unsigned READING_MAX = 127;
   // Counts at or above this give a reading past the 7-bit range.
   localparam logic [16:0] SAT_LIMIT   = 17'(US_PER_CM * (READING_MAX + 1));
   // Reciprocal of 58 scaled by 2^19; exact for every count below 16384.
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [13:0] RECIP_MULT  = 14'(((1 << RECIP_SHIFT) + US_PER_CM - 1) / US_PER_CM);

   // Polling phases of the current sensor.
   typedef enum logic [1:0] {
      PHASE_TRIGGER = 2'd0,
      PHASE_WAIT    = 2'd1,
      PHASE_COUNT   = 2'd2
   } phase_type;

   // Echo tick count to centimetres, saturated to the 7-bit store width.
   function automatic logic [6:0] reading_of(input logic [16:0] count);
      logic [26:0] product;
      product = {1'b0, count[12:0]} * {13'd0, RECIP_MULT};
      if (count >= SAT_LIMIT) begin
         reading_of = 7'(READING_MAX);
      end else begin
         reading_of = product[RECIP_SHIFT +: 7];
      end
   endfunction

endpackage

`default_nettype wire

/* sv/multichannel_ultrasonic_ranger.sv */
// Multichannel ultrasonic ranger: round-robin trigger/echo sequencer with host command decode.
// Depends on mur_pkg for constants, the phase type and the reading conversion.
//
// Usage:
//   The request channel (req_*) carries one item per transfer: a microsecond tick with
//   the sampled echo levels, or a byte received from the host. The response channel
//   (rsp_*) returns exactly one item per request: the trigger line drive, and for host
//   commands that answer, a reply byte.
//   Each request is processed in the cycle it is accepted; its response is held in an
//   output register and is offered on the following cycle.
//   Throughput is one request per cycle while the receiver keeps up: req_ready stays high
//   while the output register is empty or is being emptied in the same cycle, so a new
//   request is taken while the previous response is handed over.
//   If the receiver stalls (rsp_ready low), the response is held unchanged and
//   req_ready drops until it is taken; polling state does not advance meanwhile.
//   Reset starts sensor 0 in its trigger phase with a zero tick count, clears all
//   stored readings, sets the reported count to eight and loads the register defaults
//   (trigger 10 ticks, echo wait 1000 ticks, echo cap 5800 ticks).
//   Registers are written through the APB-style csr_* port; the user must write them only
//   while the block is idle, which the block itself does not enforce. csr_pready is always high.
`default_nettype none

module multichannel_ultrasonic_ranger (
   input  wire  logic        clock,
   input  wire  logic        reset,
   // Request channel
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic        req_command,
   input  wire  logic [7:0]  req_echo_levels,
   input  wire  logic [7:0]  req_host_byte,
   // Response channel
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [7:0]        rsp_trigger_lines,
   output logic              rsp_reply_valid,
   output logic [7:0]        rsp_reply_byte,
   // Configuration port
   input  wire  logic        csr_psel,
   input  wire  logic        csr_penable,
   input  wire  logic        csr_pwrite,
   input  wire  logic [3:0]  csr_paddr,
   input  wire  logic [31:0] csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mur_pkg::*;

   // Configuration registers
   logic [7:0]  trigger_ticks_ff;
   logic [15:0] echo_wait_limit_ff;
   logic [15:0] echo_max_ticks_ff;

   // Polling and host state
   phase_type   phase_ff, phase_in;
   logic [2:0]  sensor_index_ff, sensor_index_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [3:0]  reported_count_ff, reported_count_in;
   logic [6:0]  distance_ff [SENSORS];

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_trigger_ff, rsp_trigger_in;
   logic        rsp_reply_valid_ff, rsp_reply_valid_in;
   logic [7:0]  rsp_reply_byte_ff, rsp_reply_byte_in;

   // Working signals
   logic        req_accept;
   logic        csr_write;
   logic [2:0]  sensor;
   logic [3:0]  sensor_plus;
   logic        echo_high;
   logic [16:0] count_next;
   logic [7:0]  trigger_onehot;
   logic [6:0]  reading;
   logic        store_write;
   logic [3:0]  host_cmd;
   logic [3:0]  host_arg;

   // Handshakes: the output register frees up when its response is taken.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration write.
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff   <= TRIGGER_TICKS_RESET;
         echo_wait_limit_ff <= ECHO_WAIT_LIMIT_RESET;
         echo_max_ticks_ff  <= ECHO_MAX_TICKS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_TRIGGER_TICKS:   trigger_ticks_ff   <= csr_pwdata[7:0];
            REG_ECHO_WAIT_LIMIT: echo_wait_limit_ff <= csr_pwdata[15:0];
            REG_ECHO_MAX_TICKS:  echo_max_ticks_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Configuration read.
   always_comb begin
      case (csr_paddr[3:2])
         REG_TRIGGER_TICKS:   csr_prdata = {24'd0, trigger_ticks_ff};
         REG_ECHO_WAIT_LIMIT: csr_prdata = {16'd0, echo_wait_limit_ff};
         REG_ECHO_MAX_TICKS:  csr_prdata = {16'd0, echo_max_ticks_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // Current sensor, its echo level and the incremented tick count.
   always_comb begin
      sensor = sensor_index_ff;
      if (32'(sensor_index_ff) >= SENSORS) begin
         sensor = '0;
      end
      sensor_plus    = {1'b0, sensor} + 4'd1;
      echo_high      = req_echo_levels[sensor];
      count_next     = {1'b0, tick_count_ff} + 17'd1;
      trigger_onehot = 8'd1 << sensor;
      reading        = reading_of(count_next);
      host_cmd       = req_host_byte[7:4];
      host_arg       = req_host_byte[3:0];
   end

   // Next state and response for the accepted request.
   always_comb begin
      phase_in           = phase_ff;
      sensor_index_in    = sensor_index_ff;
      tick_count_in      = tick_count_ff;
      reported_count_in  = reported_count_ff;
      store_write        = 1'b0;
      rsp_trigger_in     = 8'd0;
      rsp_reply_valid_in = 1'b0;
      rsp_reply_byte_in  = 8'd0;

      if (req_command == KIND_TICK) begin
         case (phase_ff)
            PHASE_TRIGGER: begin
               rsp_trigger_in = trigger_onehot;
               if (count_next >= {9'd0, trigger_ticks_ff}) begin
                  phase_in      = PHASE_WAIT;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = count_next[15:0];
               end
            end
            PHASE_WAIT: begin
               if (echo_high || count_next >= {1'b0, echo_wait_limit_ff}) begin
                  phase_in      = PHASE_COUNT;
                  tick_count_in = '0;
               end else begin
                  tick_count_in = count_next[15:0];
               end
            end
            PHASE_COUNT: begin
               if (count_next > {1'b0, echo_max_ticks_ff} || !echo_high) begin
                  store_write   = 1'b1;
                  phase_in      = PHASE_TRIGGER;
                  tick_count_in = '0;
                  if (32'(sensor_plus) >= SENSORS) begin
                     sensor_index_in = '0;
                  end else begin
                     sensor_index_in = sensor_plus[2:0];
                  end
               end else begin
                  tick_count_in = count_next[15:0];
               end
            end
            default: begin
               // The spare phase code restarts the trigger of the current sensor.
               phase_in      = PHASE_TRIGGER;
               tick_count_in = '0;
            end
         endcase
      end else begin
         // Host byte: polling state is left alone, the trigger level is shown as driven.
         if (phase_ff == PHASE_TRIGGER) begin
            rsp_trigger_in = trigger_onehot;
         end
         case (host_cmd)
            CMD_NOP: ;
            CMD_SET_COUNT: reported_count_in = host_arg;
            CMD_GET_COUNT: begin
               rsp_reply_valid_in = 1'b1;
               rsp_reply_byte_in  = {4'd0, reported_count_ff};
            end
            CMD_READ: begin
               rsp_reply_valid_in = 1'b1;
               if (32'(host_arg) < SENSORS) begin
                  rsp_reply_byte_in = {1'b0, distance_ff[host_arg[2:0]]};
               end else begin
                  rsp_reply_byte_in = ERROR_REPLY;
               end
            end
            default: begin
               rsp_reply_valid_in = 1'b1;
               rsp_reply_byte_in  = ERROR_REPLY;
            end
         endcase
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   // State registers advance only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_TRIGGER;
         sensor_index_ff   <= '0;
         tick_count_ff     <= '0;
         reported_count_ff <= REPORTED_COUNT_RESET;
         for (int i = 0; i < SENSORS; i++) begin
            distance_ff[i] <= '0;
         end
      end else if (req_accept) begin
         phase_ff          <= phase_in;
         sensor_index_ff   <= sensor_index_in;
         tick_count_ff     <= tick_count_in;
         reported_count_ff <= reported_count_in;
         if (store_write) begin
            distance_ff[sensor] <= reading;
         end
      end
   end

   // Output register: valid is reset, the payload loads with each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_trigger_ff     <= rsp_trigger_in;
         rsp_reply_valid_ff <= rsp_reply_valid_in;
         rsp_reply_byte_ff  <= rsp_reply_byte_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_lines = rsp_trigger_ff;
   assign rsp_reply_valid   = rsp_reply_valid_ff;
   assign rsp_reply_byte    = rsp_reply_byte_ff;

   // At most one trigger line is ever driven.
   a_trigger_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_trigger_ff))
      else $error("more than one trigger line driven");

   // A tick in the trigger phase drives that sensor's trigger line.
   a_trigger_driven: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == KIND_TICK && phase_ff == PHASE_TRIGGER)
      |=> (rsp_trigger_ff != 8'd0))
      else $error("trigger phase tick without trigger drive");

   // Ticks never produce a host reply.
   a_tick_no_reply: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == KIND_TICK) |=> !rsp_reply_valid_ff)
      else $error("reply raised for a tick");

   // The reply byte is zero whenever no reply is flagged.
   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_reply_valid_ff) |-> (rsp_reply_byte_ff == 8'd0))
      else $error("reply byte set without reply flag");

   // The polled sensor stays within range.
   a_sensor_range: assert property (@(posedge clock) disable iff (reset)
      32'(sensor_index_ff) < SENSORS)
      else $error("sensor index out of range");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the multichannel ultrasonic ranger: directed host commands,
// a reading ended by the echo cap and shaped random polling traffic under several idling patterns.
// Depends on mur_pkg and multichannel_ultrasonic_ranger.

module testbench;
   import mur_pkg::*;

   // First host command that has no meaning and must answer with the error byte.
   localparam logic [3:0] CMD_UNUSED_LOW = 4'd4;

   // Echo cap used to end a measurement whose echo never falls.
   localparam int unsigned CAPPED_ECHO_TICKS = 200;

   typedef struct packed {
      logic [7:0] trigger_lines;
      logic       reply_valid;
      logic [7:0] reply_byte;
   } ranger_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [7:0]  req_echo_levels = 8'd0;
   logic [7:0]  req_host_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_trigger_lines;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_byte;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predicted state of the ranger and its register copies.
   phase_type   phase_now;
   logic [2:0]  sensor_now;
   logic [15:0] tick_now;
   logic [6:0]  distance_cm [SENSORS];
   logic [3:0]  reported_now;
   logic [7:0]  trigger_ticks_set;
   logic [15:0] echo_wait_set;
   logic [15:0] echo_cap_set;

   // Shaping of the echo for the measurement in progress.
   logic [16:0] echo_target;
   logic        echo_silent;

   ranger_outcome_type queued_outcomes [$];

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned error_total = 0;
   int unsigned responses_checked = 0;
   int unsigned host_replies = 0;
   int unsigned settings_written = 0;

   multichannel_ultrasonic_ranger u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_echo_levels   (req_echo_levels),
      .req_host_byte     (req_host_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trigger_lines (rsp_trigger_lines),
      .rsp_reply_valid   (rsp_reply_valid),
      .rsp_reply_byte    (rsp_reply_byte),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls at the rate the current phase asks for.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Works out the drive and reply for one request and advances the predicted state.
   function automatic ranger_outcome_type compute_outcome(input logic kind,
                                                          input logic [7:0] echo,
                                                          input logic [7:0] hb);
      ranger_outcome_type o;
      logic [2:0]  s;
      logic        high;
      logic [16:0] n;
      logic [16:0] r;
      logic [3:0]  cmd;
      logic [3:0]  arg;
      o = '0;
      s = sensor_now;
      if (kind == KIND_TICK) begin
         high = echo[s];
         n = {1'b0, tick_now} + 17'd1;
         case (phase_now)
            PHASE_TRIGGER: begin
               o.trigger_lines = 8'd1 << s;
               if (n >= {9'd0, trigger_ticks_set}) begin
                  phase_now = PHASE_WAIT;
                  tick_now = 16'd0;
               end else begin
                  tick_now = n[15:0];
               end
            end
            PHASE_WAIT: begin
               if (high || n >= {1'b0, echo_wait_set}) begin
                  phase_now = PHASE_COUNT;
                  tick_now = 16'd0;
               end else begin
                  tick_now = n[15:0];
               end
            end
            PHASE_COUNT: begin
               if (n > {1'b0, echo_cap_set} || !high) begin
                  r = 17'(n / US_PER_CM);
                  if (r > READING_MAX) r = 17'(READING_MAX);
                  distance_cm[s] = r[6:0];
                  sensor_now = (int'(s) + 1 >= SENSORS) ? 3'd0 : s + 3'd1;
                  phase_now = PHASE_TRIGGER;
                  tick_now = 16'd0;
               end else begin
                  tick_now = n[15:0];
               end
            end
            default: begin
               // The spare phase code falls back to triggering the same sensor.
               phase_now = PHASE_TRIGGER;
               tick_now = 16'd0;
            end
         endcase
      end else begin
         cmd = hb[7:4];
         arg = hb[3:0];
         // A host byte leaves polling alone; the drive shows the current trigger level.
         if (phase_now == PHASE_TRIGGER) o.trigger_lines = 8'd1 << s;
         case (cmd)
            CMD_NOP: begin
            end
            CMD_SET_COUNT: reported_now = arg;
            CMD_GET_COUNT: begin
               o.reply_valid = 1'b1;
               o.reply_byte = {4'd0, reported_now};
            end
            CMD_READ: begin
               o.reply_valid = 1'b1;
               o.reply_byte = (arg < SENSORS) ? {1'b0, distance_cm[arg[2:0]]} : ERROR_REPLY;
            end
            default: begin
               o.reply_valid = 1'b1;
               o.reply_byte = ERROR_REPLY;
            end
         endcase
      end
      return o;
   endfunction

   // Offers one request, with random idle cycles first, and records its outcome once taken.
   task automatic send_request(input logic kind, input logic [7:0] echo, input logic [7:0] hb);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= kind;
      req_echo_levels <= echo;
      req_host_byte <= hb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queued_outcomes.push_back(compute_outcome(kind, echo, hb));
   endtask

   // Stops sending and waits until every outstanding response has been checked.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (queued_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers back to back; psel stays high between the writes.
   task automatic write_settings(input logic [7:0] trig, input logic [15:0] wait_lim,
                                 input logic [15:0] cap);
      logic [1:0]  index [3];
      logic [31:0] value [3];
      index = '{REG_TRIGGER_TICKS, REG_ECHO_WAIT_LIMIT, REG_ECHO_MAX_TICKS};
      // Upper bits carry noise that the block must ignore.
      value = '{{24'($urandom), trig}, {16'($urandom), wait_lim}, {16'($urandom), cap}};
      for (int i = 0; i < 3; i++) begin
         csr_psel <= 1'b1;
         csr_pwrite <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr <= {index[i], 2'b00};
         csr_pwdata <= value[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      trigger_ticks_set = trig;
      echo_wait_set = wait_lim;
      echo_cap_set = cap;
      settings_written++;
   endtask

   // Picks one register setting: fixed extremes first, then small random ones.
   task automatic apply_setting(input int idx);
      logic [7:0]  trig;
      logic [15:0] wait_lim;
      logic [15:0] cap;
      case (idx)
         0: begin
            trig = 8'd1;
            wait_lim = 16'd1;
            cap = 16'd1;
         end
         1: begin
            // Zero trigger and wait lengths behave as one tick.
            trig = 8'd0;
            wait_lim = 16'd0;
            cap = 16'd58;
         end
         2: begin
            trig = 8'd2;
            wait_lim = 16'hFFFF;
            cap = 16'hFFFF;
         end
         3: begin
            trig = 8'hFF;
            wait_lim = 16'd3;
            cap = 16'd300;
         end
         default: begin
            trig = 8'($urandom_range(6, 1));
            wait_lim = 16'($urandom_range(40, 1));
            cap = 16'($urandom_range(400, 1));
         end
      endcase
      write_settings(trig, wait_lim, cap);
   endtask

   // One random request: mostly ticks whose echo follows a plausible measurement.
   task automatic send_shaped_item();
      logic [7:0] echo;
      logic [7:0] hb;
      logic [2:0] s;
      echo = 8'($urandom);
      hb = 8'($urandom);
      s = sensor_now;
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(9))
            0, 1, 2, 3: hb[7:4] = CMD_READ;
            4, 5: hb[7:4] = CMD_SET_COUNT;
            6: hb[7:4] = CMD_GET_COUNT;
            7: hb[7:4] = CMD_NOP;
            default: begin
            end
         endcase
         send_request(KIND_HOST, echo, hb);
      end else begin
         // One tick in ten keeps a fully random echo as noise.
         if ($urandom_range(99) >= 10) begin
            case (phase_now)
               PHASE_TRIGGER: begin
                  echo_target = ($urandom_range(1) == 0) ? 17'($urandom_range(60))
                                                         : 17'($urandom_range(300, 58));
                  echo_silent = ($urandom_range(4) == 0) && (echo_wait_set <= 16'd64);
               end
               PHASE_WAIT: echo[s] = !echo_silent && ($urandom_range(99) < 35);
               PHASE_COUNT: echo[s] = ({1'b0, tick_now} < echo_target);
               default: begin
               end
            endcase
         end
         send_request(KIND_TICK, echo, hb);
      end
   endtask

   // Every host command and the edge values, starting from the reset state.
   task automatic test_host_commands();
      idle_pct = 0;
      stall_pct = 0;
      send_request(KIND_TICK, 8'h00, 8'h00);
      send_request(KIND_HOST, 8'h00, {CMD_NOP, 4'h0});
      send_request(KIND_HOST, 8'hFF, {CMD_GET_COUNT, 4'h0});
      send_request(KIND_HOST, 8'h00, {CMD_SET_COUNT, 4'hF});
      send_request(KIND_HOST, 8'h00, {CMD_GET_COUNT, 4'hA});
      send_request(KIND_HOST, 8'h00, {CMD_SET_COUNT, 4'h0});
      send_request(KIND_HOST, 8'h00, {CMD_GET_COUNT, 4'hF});
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h0});
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h7});
      // Reading indexes past the last sensor answer with the error byte.
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h8});
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'hF});
      send_request(KIND_HOST, 8'h00, 8'hFF);
      send_request(KIND_HOST, 8'h00, {CMD_UNUSED_LOW, 4'h5});
      send_request(KIND_HOST, 8'h00, {CMD_NOP, 4'hF});
      // Run out the trigger phase with sensor 0's echo low.
      while (phase_now == PHASE_TRIGGER) send_request(KIND_TICK, 8'hFE, 8'h00);
      send_request(KIND_HOST, 8'h00, {CMD_GET_COUNT, 4'h0});
      send_request(KIND_TICK, 8'h01, 8'h00);
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h0});
      send_request(KIND_TICK, 8'hFF, 8'hFF);
      send_request(KIND_TICK, 8'h00, 8'h00);
      send_request(KIND_TICK, 8'hFF, 8'h00);
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h0});
   endtask

   // An echo that never falls is ended by the cap, and the capped reading is read back.
   task automatic test_capped_reading();
      settle();
      idle_pct = 0;
      stall_pct = 0;
      write_settings(8'd1, 16'd1, 16'(CAPPED_ECHO_TICKS));
      while (!(sensor_now == 3'd0 && phase_now == PHASE_TRIGGER)) begin
         send_request(KIND_TICK, 8'h00, 8'h00);
      end
      send_request(KIND_TICK, 8'hFF, 8'h00);
      while (phase_now != PHASE_COUNT) send_request(KIND_TICK, 8'hFF, 8'h00);
      while (phase_now == PHASE_COUNT) send_request(KIND_TICK, 8'hFF, 8'h00);
      send_request(KIND_HOST, 8'h00, {CMD_READ, 4'h0});
   endtask

   // Two register settings of shaped random traffic under one idling pattern.
   task automatic test_polling_traffic(input int unsigned idle, input int unsigned stall,
                                       input int first_setting);
      for (int k = 0; k < 2; k++) begin
         settle();
         apply_setting(first_setting + k);
         idle_pct = idle;
         stall_pct = stall;
         repeat (112) send_shaped_item();
      end
   endtask

   // Compares each accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin : check_responses
      ranger_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queued_outcomes.size() == 0) begin
            $error("response with no request outstanding: trigger_lines %0h", rsp_trigger_lines);
            error_total++;
         end else begin
            want = queued_outcomes.pop_front();
            responses_checked++;
            if (want.reply_valid) host_replies++;
            if (rsp_trigger_lines !== want.trigger_lines) begin
               $error("trigger_lines: expected %0h, got %0h", want.trigger_lines,
                      rsp_trigger_lines);
               error_total++;
            end
            if (rsp_reply_valid !== want.reply_valid) begin
               $error("reply_valid: expected %0h, got %0h", want.reply_valid, rsp_reply_valid);
               error_total++;
            end
            if (rsp_reply_byte !== want.reply_byte) begin
               $error("reply_byte: expected %0h, got %0h", want.reply_byte, rsp_reply_byte);
               error_total++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      phase_now = PHASE_TRIGGER;
      sensor_now = 3'd0;
      tick_now = 16'd0;
      for (int i = 0; i < SENSORS; i++) distance_cm[i] = 7'd0;
      reported_now = REPORTED_COUNT_RESET;
      trigger_ticks_set = TRIGGER_TICKS_RESET;
      echo_wait_set = ECHO_WAIT_LIMIT_RESET;
      echo_cap_set = ECHO_MAX_TICKS_RESET;
      echo_target = 17'd0;
      echo_silent = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_host_commands();
      test_capped_reading();
      test_polling_traffic(0, 0, 0);
      test_polling_traffic(71, 0, 2);
      test_polling_traffic(0, 71, 4);
      test_polling_traffic(8, 8, 6);
      settle();
      repeat (10) @(posedge clock);
      $display("Checked %0d responses, %0d of them host replies, over %0d register settings.",
               responses_checked, host_replies, settings_written);
      $display("Idling patterns: none, sender gaps, receiver stalls and both together.");
      if (error_total == 0) begin
         $display("multichannel_ultrasonic_ranger test passed");
      end else begin
         $display("multichannel_ultrasonic_ranger test failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("multichannel_ultrasonic_ranger test failed");
      $finish;
   end

endmodule

/* files.f */
sv/mur_pkg.sv
sv/multichannel_ultrasonic_ranger.sv
tb/sv/testbench.sv
